### hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Sizes, status codes and small helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int NUM_FRAMES    = 4096;
  localparam int FRAME_W       = 12;
  localparam int BITS_PER_WORD = 32;
  localparam int BIT_W         = 5;
  localparam int FRAME_LIMIT   = 1 << FRAME_W;

  localparam int WORD_COUNT = (NUM_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  // Only frames that fit the frame field are ever handed out.
  localparam int SEARCH_LIMIT = (NUM_FRAMES < FRAME_LIMIT) ? NUM_FRAMES : FRAME_LIMIT;
  localparam int SEARCH_WORDS = (SEARCH_LIMIT + BITS_PER_WORD - 1) / BITS_PER_WORD;

  // Two-level summary of full words: groups of words, then words in a group.
  localparam int GROUP_SIZE  = 16;
  localparam int SUB_W       = 4;
  localparam int GROUP_COUNT = (SEARCH_WORDS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int FLAG_COUNT  = GROUP_COUNT * GROUP_SIZE;
  localparam int FLAG_W      = $clog2(FLAG_COUNT);

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_MAPPED    = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOTHING   = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Bits of a word that lie at or above the search limit count as used.
  function automatic logic [BITS_PER_WORD-1:0] pad_mask(input logic [WORD_W-1:0] word);
    logic [BITS_PER_WORD-1:0] m;
    m = '0;
    for (int b = 0; b < BITS_PER_WORD; b++) begin
      m[b] = ((int'(word) * BITS_PER_WORD + b) >= SEARCH_LIMIT);
    end
    return m;
  endfunction

endpackage

### hdl/bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// First-fit physical frame allocator over a one-bit-per-frame bitmap memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate with a nonzero page_frame, a
// free of frame zero and a free at or above the frame count go from accept
// straight to the result; a free first does a read-modify-write, and an
// allocate of a new frame picks the lowest group of words that is not full (or
// reports no free frame if none is), then the lowest word in it, then does one
// read-modify-write of that bitmap word in the single-port memory, then gives
// the result. The core returns to idle as the result is registered, so the next
// request may be taken while that result still waits on out_stall. The bitmap
// is empty after reset without any clearing pass: each word carries a written flag that reset clears.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [bfa_pkg::FRAME_W-1:0] page_frame,
  input  logic                    kernel_page,
  input  logic                    writable_page,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bfa_pkg::status_t        status,
  output logic [bfa_pkg::FRAME_W-1:0] frame_number,
  output logic                    present_bit,
  output logic                    rw_bit,
  output logic                    user_bit
);
  import bfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_GROUP  = 5'b00010,
    S_WORD   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Bitmap memory and per-word written flags.
  logic [BITS_PER_WORD-1:0] bitmap_mem [WORD_COUNT];
  logic [WORD_COUNT-1:0]    word_written;
  logic [FLAG_COUNT-1:0]    word_full;

  // Request held for the whole operation.
  logic                cmd_q;
  logic                kernel_q;
  logic                writeable_q;
  logic [BIT_W-1:0]    bit_q;
  logic [WORD_W-1:0]   addr_q;
  logic [GRP_W-1:0]    grp_q;

  // Memory read port.
  logic                     rd_en;
  logic [WORD_W-1:0]        rd_addr;
  logic [BITS_PER_WORD-1:0] rd_data;
  logic                     rd_written;

  // Result waiting for the output register.
  status_t             res_status;
  logic [FRAME_W-1:0]  res_frame;
  logic                res_present;
  logic                res_rw;
  logic                res_user;

  logic                     accept;
  logic                     out_free;
  logic [GROUP_COUNT-1:0]   group_full;
  logic                     any_group;
  logic [GRP_W-1:0]         grp_pick;
  logic [SUB_W-1:0]         sub_pick;
  logic [WORD_W-1:0]        search_word;
  logic [WORD_W-1:0]        in_word;
  logic                     in_in_range;
  logic [BITS_PER_WORD-1:0] cur_word;
  logic [BITS_PER_WORD-1:0] cur_padded;
  logic [BIT_W-1:0]         zero_pick;
  logic [BIT_W-1:0]         mod_bit;
  logic [BITS_PER_WORD-1:0] new_word;
  logic                     new_full;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign in_word     = WORD_W'(page_frame >> BIT_W);
  assign in_in_range = (int'(page_frame) < NUM_FRAMES);

  // Group and word summary search.
  always_comb begin
    group_full = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      group_full[g] = &word_full[g*GROUP_SIZE +: GROUP_SIZE];
    end
    any_group = ~&group_full;
    grp_pick  = '0;
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      if (!group_full[g]) begin
        grp_pick = GRP_W'(g);
      end
    end
  end

  always_comb begin
    logic [GROUP_SIZE-1:0] sub_full;
    sub_full = word_full[int'(grp_q)*GROUP_SIZE +: GROUP_SIZE];
    sub_pick = '0;
    for (int s = GROUP_SIZE - 1; s >= 0; s--) begin
      if (!sub_full[s]) begin
        sub_pick = SUB_W'(s);
      end
    end
  end

  assign search_word = WORD_W'({grp_q, sub_pick});

  // Read-modify-write of the selected bitmap word.
  assign cur_word   = rd_written ? rd_data : '0;
  assign cur_padded = cur_word | pad_mask(addr_q);

  always_comb begin
    zero_pick = '0;
    for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
      if (!cur_padded[b]) begin
        zero_pick = BIT_W'(b);
      end
    end
  end

  assign mod_bit = (cmd_q == CMD_FREE) ? bit_q : zero_pick;

  always_comb begin
    new_word = cur_word;
    new_word[mod_bit] = (cmd_q == CMD_ALLOC);
  end

  assign new_full = &(new_word | pad_mask(addr_q));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_word;
    if (state == S_IDLE) begin
      rd_en = accept && (cmd == CMD_FREE) && (page_frame != '0) && in_in_range;
    end else if (state == S_WORD) begin
      rd_en   = 1'b1;
      rd_addr = search_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data    <= bitmap_mem[rd_addr];
      rd_written <= word_written[rd_addr];
    end
    if (state == S_MODIFY) begin
      bitmap_mem[addr_q] <= new_word;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_ALLOC) begin
            state_next = (page_frame == '0) ? S_GROUP : S_DONE;
          end else begin
            state_next = rd_en ? S_MODIFY : S_DONE;
          end
        end
      end
      S_GROUP:  state_next = any_group ? S_WORD : S_DONE;
      S_WORD:   state_next = S_MODIFY;
      S_MODIFY: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      word_written <= '0;
      for (int i = 0; i < FLAG_COUNT; i++) begin
        word_full[i] <= (i >= SEARCH_WORDS);
      end
    end else begin
      state <= state_next;
      if (state == S_MODIFY) begin
        word_written[addr_q] <= 1'b1;
        if (int'(addr_q) < SEARCH_WORDS) begin
          word_full[FLAG_W'(addr_q)] <= new_full;
        end
      end
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= cmd;
      kernel_q    <= kernel_page;
      writeable_q <= writable_page;
      bit_q       <= page_frame[BIT_W-1:0];
      addr_q      <= in_word;
      res_frame   <= '0;
      res_present <= 1'b0;
      res_rw      <= 1'b0;
      res_user    <= 1'b0;
      if (cmd == CMD_ALLOC) begin
        res_status <= ST_MAPPED;
        res_frame  <= page_frame;
      end else begin
        res_status <= (page_frame == '0) ? ST_NOTHING : ST_FREED;
      end
    end
    if (state == S_GROUP) begin
      grp_q      <= grp_pick;
      res_status <= ST_NO_FREE;
      res_frame  <= '0;
    end
    if (state == S_WORD) begin
      addr_q <= search_word;
    end
    if (state == S_MODIFY) begin
      if (cmd_q == CMD_ALLOC) begin
        res_status  <= ST_ALLOCATED;
        res_frame   <= FRAME_W'({addr_q, zero_pick});
        res_present <= 1'b1;
        res_rw      <= writeable_q;
        res_user    <= ~kernel_q;
      end else begin
        res_status <= ST_FREED;
        res_frame  <= '0;
      end
    end
  end

  // Output register: hold the beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status       <= res_status;
      frame_number <= res_frame;
      present_bit  <= res_present;
      rw_bit       <= res_rw;
      user_bit     <= res_user;
    end
  end

  // The summary must point the allocate search at a word with a clear bit.
  a_summary_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY && cmd_q == CMD_ALLOC) |-> (cur_padded != '1))
    else $error("allocate search reached a full word");

  // A no-free result only when every group is full.
  a_no_free_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_NO_FREE) |-> (&group_full))
    else $error("no-free reported while a group has room");

  // Memory modify only follows a read issue.
  a_modify_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY) |-> $past(rd_en))
    else $error("modify without a preceding read");

  // A new mapping always carries the present bit.
  a_alloc_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ALLOCATED) |-> present_bit)
    else $error("allocated beat without present bit");

endmodule
